// ===== hdl/h2r_pkg.sv =====
package h2r_pkg;

  // fixed-point formats
  localparam int unsigned HueW   = 15;
  localparam int unsigned FracW  = 16;
  localparam int unsigned SpanW  = 12;
  localparam int unsigned QuotW  = 19;
  localparam int unsigned RecipW = 20;

  localparam logic [FracW-1:0] Q15_ONE = 16'd32768;

  // hue in 1/64 degree: one 60-degree sector is 3840 units
  localparam logic [HueW-1:0] HUE_SECTOR    = 15'd3840;
  localparam logic [HueW-1:0] HUE_TWO_SECT  = 15'd7680;
  localparam logic [HueW-1:0] HUE_FOUR_SECT = 15'd15360;
  localparam logic [HueW-1:0] HUE_SIX_SECT  = 15'd23040;
  localparam logic [HueW-1:0] HUE_EIGHT_SECT = 15'd30720;

  localparam logic [HueW-1:0] HUE_SECT_1 = 15'd3840;
  localparam logic [HueW-1:0] HUE_SECT_2 = 15'd7680;
  localparam logic [HueW-1:0] HUE_SECT_3 = 15'd11520;
  localparam logic [HueW-1:0] HUE_SECT_4 = 15'd15360;
  localparam logic [HueW-1:0] HUE_SECT_5 = 15'd19200;

  // divide by 15 as multiply by ceil(2^23 / 15) then shift by 23
  localparam logic [RecipW-1:0] RECIP_15    = 20'd559241;
  localparam int unsigned       RecipShift  = 23;

  // 60-degree sector of the hue; everything from 300 degrees up is the last one
  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYN  = 3'd2,
    SEC_CYN_BLU  = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } sector_t;

endpackage

// ===== hdl/hsv_to_rgb_converter.sv =====
// hsv(a) to rgb(a) pixel converter, four register stages
// throughput: 1 item per cycle while the output is not stalled;
//   stage 1 holds the val*sat multiplier, stage 2 the chroma*span multiplier,
//   stage 3 the divide-by-15 reciprocal multiplier
// a stalled output holds its stage; empty stages ahead keep accepting
// reset (synchronous, active low) clears the stage valid bits only
module hsv_to_rgb_converter import h2r_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [HueW-1:0]  in_hue,
  input  logic [FracW-1:0] in_sat,
  input  logic [FracW-1:0] in_val,
  input  logic [FracW-1:0] in_alpha,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [FracW-1:0] out_red,
  output logic [FracW-1:0] out_green,
  output logic [FracW-1:0] out_blue,
  output logic [FracW-1:0] out_alpha_out
);

  // stage valid bits and advance enables
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  assign en4 = !v4_r || out_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // ---------------- stage 1: clamp, sector, span, val*sat ----------------
  logic [FracW-1:0]   sat_c, val_c;
  logic [HueW-1:0]    hue_mod;
  logic [SpanW-1:0]   span_nxt;
  sector_t            sec1_nxt;
  logic [2*FracW-1:0] vs_nxt;

  always_comb begin
    sat_c = (in_sat > Q15_ONE) ? Q15_ONE : in_sat;
    val_c = (in_val > Q15_ONE) ? Q15_ONE : in_val;
    vs_nxt = val_c * sat_c;

    // hue mod two sectors
    if (in_hue >= HUE_EIGHT_SECT)      hue_mod = in_hue - HUE_EIGHT_SECT;
    else if (in_hue >= HUE_SIX_SECT)   hue_mod = in_hue - HUE_SIX_SECT;
    else if (in_hue >= HUE_FOUR_SECT)  hue_mod = in_hue - HUE_FOUR_SECT;
    else if (in_hue >= HUE_TWO_SECT)   hue_mod = in_hue - HUE_TWO_SECT;
    else                               hue_mod = in_hue;

    // span = sector - |hue_mod - sector|, 0..3840
    if (hue_mod < HUE_SECTOR) span_nxt = hue_mod[SpanW-1:0];
    else                      span_nxt = SpanW'(HUE_TWO_SECT - hue_mod);

    if (in_hue >= HUE_SECT_5)      sec1_nxt = SEC_MAG_RED;
    else if (in_hue >= HUE_SECT_4) sec1_nxt = SEC_BLU_MAG;
    else if (in_hue >= HUE_SECT_3) sec1_nxt = SEC_CYN_BLU;
    else if (in_hue >= HUE_SECT_2) sec1_nxt = SEC_GRN_CYN;
    else if (in_hue >= HUE_SECT_1) sec1_nxt = SEC_YEL_GRN;
    else                           sec1_nxt = SEC_RED_YEL;
  end

  logic [FracW-1:0]   val1_r, alpha1_r;
  logic [SpanW-1:0]   span1_r;
  sector_t            sec1_r;
  logic [2*FracW-2:0] vs1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      val1_r   <= val_c;
      alpha1_r <= in_alpha;
      span1_r  <= span_nxt;
      sec1_r   <= sec1_nxt;
      vs1_r    <= vs_nxt[2*FracW-2:0];
    end
  end

  // ---------------- stage 2: chroma, m, chroma*span ----------------
  logic [FracW-1:0]       c2_nxt, m2_nxt;
  logic [FracW+SpanW-1:0] cw2_nxt;

  assign c2_nxt  = vs1_r[2*FracW-2:FracW-1];
  assign m2_nxt  = val1_r - c2_nxt;
  assign cw2_nxt = c2_nxt * span1_r;

  logic [FracW-1:0]   c2_r, m2_r, alpha2_r;
  logic [QuotW-1:0]   q2_r;
  sector_t            sec2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      c2_r     <= c2_nxt;
      m2_r     <= m2_nxt;
      alpha2_r <= alpha1_r;
      sec2_r   <= sec1_r;
      // divide by 256 here, the remaining factor of 15 in stage 3
      q2_r     <= cw2_nxt[QuotW+7:8];
    end
  end

  // ---------------- stage 3: divide by 15 via reciprocal ----------------
  logic [QuotW+RecipW-1:0] qk3_nxt;

  assign qk3_nxt = q2_r * RECIP_15;

  logic [FracW-1:0] c3_r, m3_r, alpha3_r, x3_r;
  sector_t          sec3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      c3_r     <= c2_r;
      m3_r     <= m2_r;
      alpha3_r <= alpha2_r;
      sec3_r   <= sec2_r;
      x3_r     <= qk3_nxt[RecipShift+FracW-1:RecipShift];
    end
  end

  // ---------------- stage 4: sector permutation plus m ----------------
  logic [FracW-1:0] r_sel, g_sel, b_sel;

  always_comb begin
    case (sec3_r)
      SEC_RED_YEL: begin r_sel = c3_r;  g_sel = x3_r;  b_sel = '0;    end
      SEC_YEL_GRN: begin r_sel = x3_r;  g_sel = c3_r;  b_sel = '0;    end
      SEC_GRN_CYN: begin r_sel = '0;    g_sel = c3_r;  b_sel = x3_r;  end
      SEC_CYN_BLU: begin r_sel = '0;    g_sel = x3_r;  b_sel = c3_r;  end
      SEC_BLU_MAG: begin r_sel = x3_r;  g_sel = '0;    b_sel = c3_r;  end
      default: begin r_sel = c3_r;  g_sel = '0;    b_sel = x3_r;  end
    endcase
  end

  logic [FracW-1:0] red_r, green_r, blue_r, alpha4_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      red_r    <= r_sel + m3_r;
      green_r  <= g_sel + m3_r;
      blue_r   <= b_sel + m3_r;
      alpha4_r <= alpha3_r;
    end
  end

  assign out_valid     = v4_r;
  assign out_red       = red_r;
  assign out_green     = green_r;
  assign out_blue      = blue_r;
  assign out_alpha_out = alpha4_r;

  // ---------------- checks ----------------
  // a full pipeline behind a stalled output takes no item
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && v4_r && !out_ready) |-> !in_ready)
    else $error("item accepted into a full stalled pipeline");

  // an accepted item always lands in stage 1
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted item lost at stage 1");

  // the secondary component never exceeds chroma
  a_x_le_c: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (x3_r <= c3_r))
    else $error("secondary component above chroma");

  // every color output stays within one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red <= Q15_ONE && out_green <= Q15_ONE && out_blue <= Q15_ONE))
    else $error("color component above one");

  // a stalled stage 3 item is not overwritten
  a_hold3: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !en3) |=> (v3_r && $stable(x3_r) && $stable(c3_r)))
    else $error("stalled stage 3 item changed");

endmodule
